// ===== design/ttdd_pkg.sv =====
package ttdd_pkg;

  typedef struct packed {
    logic frame_start;
    logic first_row;
    logic last;
  } col_flags_t;

  localparam logic [7:0] WidthReset = 8'd128;
  localparam logic [7:0] WidthMin   = 8'd2;
  localparam logic [9:0] FullScale  = 10'd255;

  function automatic logic [7:0] add_clamp(input logic [7:0] v, input logic [6:0] e);
    logic signed [9:0] s;
    s = $signed({2'b00, v}) + $signed({{3{e[6]}}, e});
    if (s < 0) begin
      return 8'd0;
    end else if (s > $signed(FullScale)) begin
      return 8'd255;
    end else begin
      return s[7:0];
    end
  endfunction

  function automatic logic [6:0] quant_err(input logic [7:0] v);
    logic signed [9:0] d;
    d = $signed({2'b00, v});
    if (v[7]) begin
      d = d - $signed(FullScale);
    end
    d = d >>> 1;
    return d[6:0];
  endfunction

endpackage

// ===== design/ttdd_line_mem.sv =====
module ttdd_line_mem #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [6:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [6:0]    rdata
);

  logic [6:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/ttdd_col_ctrl.sv =====
module ttdd_col_ctrl #(
  parameter int MAX_WIDTH = 128,
  parameter int CW        = 7
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic                frame_start,
  input  logic [7:0]          line_width,
  output logic [CW-1:0]       col,
  output ttdd_pkg::col_flags_t flags
);
  import ttdd_pkg::*;

  localparam int MW = (CW > 8) ? CW : 8;

  logic [CW-1:0] column_count;
  logic [CW-1:0] column_count_next;
  logic          first_row;
  logic          first_row_next;
  logic [MW:0]   eff_width;
  logic          fr;
  logic          last;

  always_comb begin
    if (line_width < WidthMin) begin
      eff_width = (MW+1)'(WidthMin);
    end else if (int'(line_width) > MAX_WIDTH) begin
      eff_width = (MW+1)'(MAX_WIDTH);
    end else begin
      eff_width = (MW+1)'(line_width);
    end
    col  = frame_start ? '0 : column_count;
    fr   = frame_start | first_row;
    last = (MW+1)'(col) >= (eff_width - (MW+1)'(1));
    column_count_next = last ? '0 : col + CW'(1);
    first_row_next    = last ? 1'b0 : fr;
    flags.frame_start = frame_start;
    flags.first_row   = fr;
    flags.last        = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      first_row    <= 1'b1;
    end else if (accept) begin
      column_count <= column_count_next;
      first_row    <= first_row_next;
    end
  end

endmodule

// ===== design/two_tap_error_diffusion_dither_top.sv =====
// channel  | signals                         | handshake
// input    | grey_value, frame_start         | in_valid / in_stall
// output   | pixel_white                     | out_valid / out_stall
// config   | line_width                      | cfg_valid / cfg_ready
// One item per cycle while out_stall is low; each item passes the s1 and output registers.
// The line memory is read when the item is taken and written when it leaves s1,
// with a bypass when the next item reads the entry being written.
// rst is synchronous: line_width returns to 128, column and left error clear.
// The line memory is not cleared; the first row of a frame never uses it.
// in_stall rises only while the output register holds a stalled result.
module two_tap_error_diffusion_dither_top #(
  parameter int MAX_WIDTH = 128
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] grey_value,
  input  logic       frame_start,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       pixel_white,
  output logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] line_width,
  input  logic       cfg_valid,
  output logic       cfg_ready
);
  import ttdd_pkg::*;

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic [7:0]    width_reg;
  logic          accept;
  logic [CW-1:0] col_in;
  col_flags_t    flags_in;

  logic          s1_valid;
  logic [7:0]    s1_grey;
  logic [CW-1:0] s1_col;
  col_flags_t    s1_flags;
  logic          fwd_hit;
  logic [6:0]    fwd_data;
  logic [6:0]    mem_rdata;
  logic          s1_adv;

  logic [6:0]    left_error;
  logic [6:0]    left_use;
  logic [6:0]    up_err;
  logic [7:0]    adj_up;
  logic [7:0]    adj;
  logic [6:0]    err;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg <= WidthReset;
    end else if (cfg_valid && cfg_ready) begin
      width_reg <= line_width;
    end
  end

  assign s1_adv   = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_adv;
  assign accept   = in_valid && !in_stall;

  ttdd_col_ctrl #(
    .MAX_WIDTH (MAX_WIDTH),
    .CW        (CW)
  ) u_col (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .frame_start (frame_start),
    .line_width  (width_reg),
    .col         (col_in),
    .flags       (flags_in)
  );

  ttdd_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_mem (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col),
    .wdata (err),
    .re    (accept),
    .raddr (col_in),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_grey  <= grey_value;
      s1_col   <= col_in;
      s1_flags <= flags_in;
      fwd_hit  <= s1_adv && (s1_col == col_in);
      fwd_data <= err;
    end
  end

  always_comb begin
    up_err   = fwd_hit ? fwd_data : mem_rdata;
    left_use = s1_flags.frame_start ? 7'd0 : left_error;
    adj_up   = s1_flags.first_row ? s1_grey : add_clamp(s1_grey, up_err);
    adj      = add_clamp(adj_up, left_use);
    err      = quant_err(adj);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_error <= 7'd0;
    end else if (s1_adv) begin
      left_error <= s1_flags.last ? 7'd0 : err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      pixel_white <= adj[7];
    end
  end

endmodule

// ===== design/ttdd_checker.sv =====
module ttdd_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic pixel_white
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pixel_white))
    else $error("stalled result changed");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  a_result_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without a taken item");

endmodule

bind two_tap_error_diffusion_dither_top ttdd_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .pixel_white (pixel_white)
);

// ===== bench/two_tap_error_diffusion_dither_top_tb.sv =====
`timescale 1ns / 1ps

module two_tap_error_diffusion_dither_top_tb;
  import ttdd_pkg::*;

  localparam int MaxWidth       = 128;
  localparam int FullWhite      = 255;
  localparam int WhiteThreshold = 128;
  localparam int RandomPixels   = 1650;
  localparam int QuietAfter     = 1400;
  localparam int SettleCycles   = 4;

  typedef struct packed {
    logic [7:0] grey;
    logic       start;
  } pixel_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic [7:0] grey_value = '0;
  logic       frame_start = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       pixel_white;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] line_width = '0;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;

  pixel_t pending_pixels[$];
  logic   expected_white[$];
  pixel_t next_px;
  logic   want_white;
  int     mismatch_count = 0;
  int     gap_left = 0;
  int     stall_left = 0;
  bit     idle_en = 1'b1;

  // predictor state
  logic [6:0] err_row[MaxWidth];
  logic [6:0] err_left = '0;
  int         cur_col = 0;
  logic       top_row = 1'b1;
  logic [7:0] width_reg = WidthReset;

  two_tap_error_diffusion_dither_top dut (
    .clk        (clk),
    .rst        (rst),
    .grey_value (grey_value),
    .frame_start(frame_start),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .pixel_white(pixel_white),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .line_width (line_width),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic int eff_width(input logic [7:0] w);
    if (w < WidthMin) begin
      return int'(WidthMin);
    end
    if (w > MaxWidth) begin
      return MaxWidth;
    end
    return int'(w);
  endfunction

  function automatic int clamp_pixel(input int v);
    if (v < 0) begin
      return 0;
    end
    if (v > FullWhite) begin
      return FullWhite;
    end
    return v;
  endfunction

  function automatic logic dither_pixel(input logic [7:0] grey, input logic start);
    int   eff;
    int   c;
    int   adj;
    int   err;
    logic last;
    logic white;
    eff = eff_width(width_reg);
    if (start) begin
      cur_col  = 0;
      top_row  = 1'b1;
      err_left = '0;
    end
    c = cur_col;
    last = (c >= eff - 1);
    if (c >= MaxWidth) begin
      c = MaxWidth - 1;
    end
    adj = int'(grey);
    if (!top_row) begin
      adj = clamp_pixel(adj + int'($signed(err_row[c])));
    end
    adj = clamp_pixel(adj + int'($signed(err_left)));
    white = (adj >= WhiteThreshold);
    err = white ? ((adj - FullWhite) >>> 1) : (adj >>> 1);
    err_row[c] = err[6:0];
    if (last) begin
      err_left = '0;
      cur_col  = 0;
      top_row  = 1'b0;
    end else begin
      err_left = err[6:0];
      cur_col  = c + 1;
    end
    return white;
  endfunction

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_white.push_back(dither_pixel(grey_value, frame_start));
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_pixels.size() > 0) begin
          next_px = pending_pixels.pop_front();
          grey_value  <= next_px.grey;
          frame_start <= next_px.start;
          in_valid    <= 1'b1;
          if (idle_en && $urandom_range(0, 9) == 0) begin
            gap_left = $urandom_range(1, 14);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output backpressure
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (idle_en && $urandom_range(0, 11) == 0) begin
      stall_left = $urandom_range(1, 14) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_white.size() == 0) begin
        $display("%0t: unexpected item, pixel_white expected none actual %0b",
                 $time, pixel_white);
        mismatch_count++;
      end else begin
        want_white = expected_white.pop_front();
        if (pixel_white !== want_white) begin
          $display("%0t: pixel_white expected %0b actual %0b",
                   $time, want_white, pixel_white);
          mismatch_count++;
        end
      end
    end
  end

  task automatic push_pixel(input logic [7:0] grey, input logic start);
    pixel_t p;
    p.grey  = grey;
    p.start = start;
    pending_pixels.push_back(p);
  endtask

  task automatic wait_drained();
    do begin
      @(negedge clk);
    end while (pending_pixels.size() != 0 || in_valid || expected_white.size() != 0);
  endtask

  task automatic write_width(input logic [7:0] w);
    repeat (SettleCycles) @(posedge clk);
    line_width <= w;
    cfg_valid  <= 1'b1;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    width_reg = w;
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic fill_random(input int n, input int eff, input bit fs_needed);
    int         pos;
    int         frame_len;
    int         mode;
    logic       fs;
    logic [7:0] g;
    pos = 0;
    frame_len = eff * $urandom_range(2, 4);
    mode = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) begin
      fs = 1'b0;
      if (i == 0) begin
        fs = fs_needed;
      end else if (pos >= frame_len) begin
        fs = 1'b1;
        pos = 0;
        frame_len = eff * $urandom_range(2, 4);
        mode = $urandom_range(0, 3);
      end else if ($urandom_range(0, 299) == 0) begin
        // broken frame
        fs = 1'b1;
        pos = 0;
      end
      case (mode)
        0: g = 8'($urandom_range(0, 255));
        1: g = $urandom_range(0, 1) ? 8'(255 - $urandom_range(0, 3)) : 8'($urandom_range(0, 3));
        2: g = 8'(pos * 5 + $urandom_range(0, 3));
        default: g = 8'(WhiteThreshold - 20 + $urandom_range(0, 40));
      endcase
      push_pixel(g, fs);
      pos++;
    end
  endtask

  initial begin
    logic [7:0] width_plan[7];
    logic [7:0] w;
    int         total;
    int         n;
    int         eff_now;
    int         eff_next;
    int         k;
    width_plan = '{8'd2, 8'd128, 8'd129, 8'd0, 8'd1, 8'd255, 8'd64};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset width, frame start mid-row
    push_pixel(8'd255, 1'b1);
    push_pixel(8'd0,   1'b0);
    push_pixel(8'd127, 1'b0);
    push_pixel(8'd128, 1'b0);
    push_pixel(8'd255, 1'b1);
    push_pixel(8'd0,   1'b0);
    wait_drained();

    // narrower width mid-row, then several short rows
    write_width(8'd3);
    push_pixel(8'd200, 1'b0);
    push_pixel(8'd0,   1'b0);
    push_pixel(8'd255, 1'b0);
    push_pixel(8'd128, 1'b0);
    push_pixel(8'd127, 1'b0);
    push_pixel(8'd1,   1'b0);
    push_pixel(8'd254, 1'b0);
    push_pixel(8'd60,  1'b0);
    push_pixel(8'd255, 1'b0);
    wait_drained();

    // width below minimum, column past the new end
    write_width(8'd1);
    push_pixel(8'd255, 1'b0);
    push_pixel(8'd0,   1'b0);
    push_pixel(8'd0,   1'b0);
    push_pixel(8'd255, 1'b0);
    push_pixel(8'd128, 1'b0);
    push_pixel(8'd127, 1'b0);
    wait_drained();

    // width above maximum
    write_width(8'd255);
    push_pixel(8'd0,   1'b1);
    push_pixel(8'd255, 1'b0);
    push_pixel(8'd255, 1'b0);
    push_pixel(8'd0,   1'b0);
    wait_drained();

    write_width(8'd0);
    push_pixel(8'd128, 1'b0);
    push_pixel(8'd128, 1'b0);
    wait_drained();

    total = 0;
    k = 0;
    eff_now = eff_width(width_reg);
    while (total < RandomPixels) begin
      if (k < 7) begin
        w = width_plan[k];
      end else if ($urandom_range(0, 3) == 0) begin
        w = 8'($urandom_range(0, 255));
      end else begin
        w = 8'($urandom_range(2, 20));
      end
      k++;
      eff_next = eff_width(w);
      n = $urandom_range(90, 180);
      if (n < 2 * eff_next + 10) begin
        n = 2 * eff_next + 10;
      end
      idle_en = (total >= QuietAfter) ? 1'b0 : ($urandom_range(0, 3) != 0);
      write_width(w);
      // a wider row would read entries never written, so restart the frame
      fill_random(n, eff_next, eff_next > eff_now);
      wait_drained();
      total += n;
      eff_now = eff_next;
    end

    repeat (SettleCycles) @(posedge clk);
    if (mismatch_count == 0 && expected_white.size() == 0) begin
      $display("CHECK OK");
    end else begin
      if (expected_white.size() != 0) begin
        $display("%0t: %0d expected items never arrived", $time, expected_white.size());
      end
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("%0t: timeout", $time);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
design/ttdd_pkg.sv
design/ttdd_line_mem.sv
design/ttdd_col_ctrl.sv
design/two_tap_error_diffusion_dither_top.sv
design/ttdd_checker.sv
bench/two_tap_error_diffusion_dither_top_tb.sv
